[rtl/core/jt_pkg.sv]
`timescale 1ns / 1ps

package jt_pkg;

  localparam int unsigned MaxTokenLen = 32;
  // length counters cover the whole legal range of the token length
  localparam int unsigned LenW        = 6;
  localparam int unsigned KwCntW      = 3;
  localparam int unsigned CmdDepth    = 2;
  localparam int unsigned OutDepth    = 4;

  typedef enum logic [3:0] {
    TK_LBRACE = 4'd0,
    TK_RBRACE = 4'd1,
    TK_LBRACK = 4'd2,
    TK_RBRACK = 4'd3,
    TK_COLON  = 4'd4,
    TK_COMMA  = 4'd5,
    TK_STRING = 4'd6,
    TK_INT    = 4'd7,
    TK_FLOAT  = 4'd8,
    TK_TRUE   = 4'd9,
    TK_FALSE  = 4'd10,
    TK_NULL   = 4'd11
  } token_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_ESCAPE    = 3'd1,
    ERR_KEYWORD   = 3'd2,
    ERR_SYMBOL    = 3'd3,
    ERR_TOO_LONG  = 3'd4,
    ERR_UNTERM    = 3'd5
  } error_code_e;

  typedef enum logic [6:0] {
    M_IDLE = 7'b0000001,
    M_STR  = 7'b0000010,
    M_ESC  = 7'b0000100,
    M_INT  = 7'b0001000,
    M_FRAC = 7'b0010000,
    M_KEY  = 7'b0100000,
    M_ERR  = 7'b1000000
  } mode_e;

  typedef enum logic [2:0] {
    ST_FLUSH = 3'b001,
    ST_A     = 3'b010,
    ST_B     = 3'b100
  } step_e;

  localparam logic [39:0] KwTrue  = {"true", 8'h00};
  localparam logic [39:0] KwFalse = "false";
  localparam logic [39:0] KwNull  = {"null", 8'h00};

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] vbyte;
    logic       bvalid;
    logic       tend;
    logic [2:0] err;
  } item_t;

  typedef struct packed {
    item_t item;
    logic  last;
  } res_t;

  // one command: optional number flush from a buffer half, then up to two items
  typedef struct packed {
    logic            flush;
    logic            fbank;
    logic [3:0]      fkind;
    logic [LenW-1:0] fcount;
    logic            a_v;
    item_t           a;
    logic            b_v;
    item_t           b;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } done_t;

  typedef struct packed {
    mode_e mode;
    logic  emit;
    item_t item;
    logic  num_start;
    logic  kw_start;
  } idle_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_kw_letter(logic [7:0] c);
    return (c == "t") || (c == "r") || (c == "u") || (c == "e") || (c == "f") ||
           (c == "a") || (c == "l") || (c == "s") || (c == "n");
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09);
  endfunction

  // letter c at position pos matches the keyword word of length wlen
  function automatic logic kw_char_ok(logic [39:0] word, logic [KwCntW-1:0] wlen,
                                      logic [KwCntW-1:0] pos, logic [7:0] c);
    logic [7:0] ch;
    ch = 8'h00;
    for (int i = 0; i < 5; i++) begin
      if (pos == KwCntW'(i)) ch = word[39 - 8*i -: 8];
    end
    return (pos < wlen) && (c == ch);
  endfunction

  function automatic item_t err_item(error_code_e code);
    item_t r;
    r = '0;
    r.err = code;
    return r;
  endfunction

  function automatic item_t tok_item(token_kind_e kind);
    item_t r;
    r = '0;
    r.kind = kind;
    r.tend = 1'b1;
    return r;
  endfunction

  function automatic idle_t idle_byte(logic [7:0] c);
    idle_t r;
    r = '0;
    r.mode = M_IDLE;
    priority if (is_space(c)) begin
      r.emit = 1'b0;
    end else if (c == "{") begin
      r.emit = 1'b1;
      r.item = tok_item(TK_LBRACE);
    end else if (c == "}") begin
      r.emit = 1'b1;
      r.item = tok_item(TK_RBRACE);
    end else if (c == "[") begin
      r.emit = 1'b1;
      r.item = tok_item(TK_LBRACK);
    end else if (c == "]") begin
      r.emit = 1'b1;
      r.item = tok_item(TK_RBRACK);
    end else if (c == ":") begin
      r.emit = 1'b1;
      r.item = tok_item(TK_COLON);
    end else if (c == ",") begin
      r.emit = 1'b1;
      r.item = tok_item(TK_COMMA);
    end else if (c == "\"") begin
      r.mode = M_STR;
    end else if (is_digit(c) || (c == "-")) begin
      r.mode      = M_INT;
      r.num_start = 1'b1;
    end else if (is_kw_letter(c)) begin
      r.mode     = M_KEY;
      r.kw_start = 1'b1;
    end else begin
      r.mode = M_ERR;
      r.emit = 1'b1;
      r.item = err_item(ERR_SYMBOL);
    end
    return r;
  endfunction

endpackage

[rtl/core/json_tokenizer.sv]
`timescale 1ns / 1ps
// path: each result passes the command queue, the stage register and the result queue
// throughput: one byte and one result per cycle while the result queue has room; a
// number flush reads one buffered byte per cycle; input stalls while the command queue
// is full or while a buffer half that the next number could need is still being flushed
// reset: rst_ni is asynchronous, active low; both queues empty, lexer idle

module json_tokenizer #(
  parameter int unsigned MAX_TOKEN_LEN = jt_pkg::MaxTokenLen
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_byte_i,
  input  logic       end_of_text_i,
  output logic       empty,
  input  logic       pop,
  output logic [3:0] token_kind_o,
  output logic [7:0] value_byte_o,
  output logic       byte_valid_o,
  output logic       token_end_o,
  output logic [2:0] error_code_o,
  output logic       last_o
);

  localparam int unsigned IdxW     = $clog2(MAX_TOKEN_LEN);
  localparam int unsigned RamDepth = 2 * (2 ** IdxW);

  jt_pkg::cmd_t  cmd_in, cmd_head;
  logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
  jt_pkg::done_t done;
  jt_pkg::res_t  res;
  logic          ram_we, ram_re;
  logic [IdxW:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  jt_front #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .cmd_o         (cmd_in),
    .cmd_push_o    (cmd_push),
    .cmd_full_i    (cmd_full),
    .done_i        (done),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata)
  );

  jt_fifo #(
    .WIDTH ($bits(jt_pkg::cmd_t)),
    .DEPTH (jt_pkg::CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty),
    .cnt_o   ()
  );

  jt_ram #(
    .WIDTH (8),
    .DEPTH (RamDepth)
  ) u_token_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  jt_back #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .done_o      (done),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  assign token_kind_o = res.item.kind;
  assign value_byte_o = res.item.vbyte;
  assign byte_valid_o = res.item.bvalid;
  assign token_end_o  = res.item.tend;
  assign error_code_o = res.item.err;
  assign last_o       = res.last;

  // the flush read and a new number never touch the same buffer half
  a_buf_halves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr[IdxW] != ram_raddr[IdxW]))
    else $error("token buffer write and flush read hit the same half");

  a_cmd_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !cmd_full)
    else $error("command queue written while full");

  a_done_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done.valid |-> (!cmd_empty && cmd_head.flush && (cmd_head.fbank == done.bank)))
    else $error("flush completion without a flush command");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (error_code_o != jt_pkg::ERR_NONE)) |-> (!token_end_o && !byte_valid_o))
    else $error("error result carries token data");

endmodule

[rtl/core/jt_ram.sv]
`timescale 1ns / 1ps

module jt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/jt_fifo.sv]
`timescale 1ns / 1ps

module jt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = jt_pkg::OutDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  output logic                       full_o,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] cnt_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

[rtl/core/jt_front.sv]
`timescale 1ns / 1ps

module jt_front #(
  parameter int unsigned MAX_TOKEN_LEN = jt_pkg::MaxTokenLen
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full_o,
  input  logic [7:0]                       text_byte_i,
  input  logic                             end_of_text_i,
  output jt_pkg::cmd_t                     cmd_o,
  output logic                             cmd_push_o,
  input  logic                             cmd_full_i,
  input  jt_pkg::done_t                    done_i,
  output logic                             ram_we_o,
  output logic [$clog2(MAX_TOKEN_LEN):0]   ram_waddr_o,
  output logic [7:0]                       ram_wdata_o
);

  localparam int unsigned IdxW = $clog2(MAX_TOKEN_LEN);
  localparam int unsigned LenW = jt_pkg::LenW;
  localparam int unsigned KcW  = jt_pkg::KwCntW;

  jt_pkg::mode_e    mode_q, mode_d;
  logic [LenW-1:0]  len_q, len_d, dot_q, dot_d;
  logic             nz_q, nz_d;
  logic [KcW-1:0]   kcnt_q, kcnt_d;
  logic             mt_q, mt_d, mf_q, mf_d, mn_q, mn_d;
  logic             bank_q, bank_d;
  logic [1:0]       pend_q, pend_d, pend_clr;

  jt_pkg::cmd_t     cmd;
  jt_pkg::idle_t    id;
  logic             accept, in_num, buf_full;
  logic             do_flush, do_clear, do_idle, do_kw;
  logic             kw_ok;
  jt_pkg::token_kind_e kw_kind;
  logic             we, wbank;
  logic [IdxW-1:0]  widx;
  logic [7:0]       c;

  function automatic logic is_digit_or_dot(logic [7:0] ch, jt_pkg::mode_e m);
    return jt_pkg::is_digit(ch) || ((ch == ".") && (m == jt_pkg::M_INT));
  endfunction

  assign c        = text_byte_i;
  assign in_num   = (mode_q == jt_pkg::M_INT) || (mode_q == jt_pkg::M_FRAC);
  // a number start writes the other buffer half when it also ends a number
  assign full_o   = cmd_full_i || pend_q[bank_q] || (in_num && pend_q[~bank_q]);
  assign accept   = push_i && !full_o;
  assign buf_full = (len_q >= LenW'(MAX_TOKEN_LEN));
  assign pend_clr = done_i.valid ? (done_i.bank ? 2'b10 : 2'b01) : 2'b00;

  always_comb begin
    kw_ok   = 1'b1;
    kw_kind = jt_pkg::TK_TRUE;
    priority if (mt_q && (kcnt_q == KcW'(4))) begin
      kw_kind = jt_pkg::TK_TRUE;
    end else if (mf_q && (kcnt_q == KcW'(5))) begin
      kw_kind = jt_pkg::TK_FALSE;
    end else if (mn_q && (kcnt_q == KcW'(4))) begin
      kw_kind = jt_pkg::TK_NULL;
    end else begin
      kw_ok = 1'b0;
    end
  end

  always_comb begin
    mode_d   = mode_q;
    len_d    = len_q;
    dot_d    = dot_q;
    nz_d     = nz_q;
    kcnt_d   = kcnt_q;
    mt_d     = mt_q;
    mf_d     = mf_q;
    mn_d     = mn_q;
    bank_d   = bank_q;
    pend_d   = pend_q & ~pend_clr;
    cmd      = '0;
    we       = 1'b0;
    widx     = len_q[IdxW-1:0];
    wbank    = bank_q;
    do_flush = 1'b0;
    do_clear = 1'b0;
    do_idle  = 1'b0;
    do_kw    = 1'b0;
    id       = jt_pkg::idle_byte(c);

    if (accept) begin
      if (end_of_text_i) begin
        unique case (mode_q)
          jt_pkg::M_INT, jt_pkg::M_FRAC: do_flush = 1'b1;
          jt_pkg::M_KEY:                 do_kw = 1'b1;
          jt_pkg::M_STR, jt_pkg::M_ESC: begin
            cmd.a_v = 1'b1;
            cmd.a   = jt_pkg::err_item(jt_pkg::ERR_UNTERM);
          end
          default: ;
        endcase
        do_clear = 1'b1;
      end else begin
        unique case (mode_q)
          jt_pkg::M_IDLE: do_idle = 1'b1;
          jt_pkg::M_STR: begin
            cmd.a.kind = jt_pkg::TK_STRING;
            if (c == "\"") begin
              cmd.a_v    = 1'b1;
              cmd.a.tend = 1'b1;
              mode_d     = jt_pkg::M_IDLE;
            end else if (c == "\\") begin
              mode_d = jt_pkg::M_ESC;
            end else begin
              cmd.a_v      = 1'b1;
              cmd.a.vbyte  = c;
              cmd.a.bvalid = 1'b1;
            end
          end
          jt_pkg::M_ESC: begin
            cmd.a_v      = 1'b1;
            cmd.a.kind   = jt_pkg::TK_STRING;
            cmd.a.bvalid = 1'b1;
            mode_d       = jt_pkg::M_STR;
            priority if (c == "\"") begin
              cmd.a.vbyte = "\"";
            end else if (c == "b") begin
              cmd.a.vbyte = 8'h08;
            end else if (c == "f") begin
              cmd.a.vbyte = 8'h0C;
            end else if (c == "n") begin
              cmd.a.vbyte = 8'h0A;
            end else if (c == "t") begin
              cmd.a.vbyte = 8'h09;
            end else if (c == "\\") begin
              cmd.a.vbyte = "\\";
            end else begin
              cmd.a    = jt_pkg::err_item(jt_pkg::ERR_ESCAPE);
              mode_d   = jt_pkg::M_ERR;
              do_clear = 1'b1;
            end
          end
          jt_pkg::M_INT, jt_pkg::M_FRAC: begin
            if (is_digit_or_dot(c, mode_q)) begin
              if (buf_full) begin
                cmd.a_v  = 1'b1;
                cmd.a    = jt_pkg::err_item(jt_pkg::ERR_TOO_LONG);
                mode_d   = jt_pkg::M_ERR;
                do_clear = 1'b1;
              end else begin
                we    = 1'b1;
                len_d = len_q + 1'b1;
                if (c == ".") begin
                  dot_d  = len_q;
                  mode_d = jt_pkg::M_FRAC;
                end else if ((mode_q == jt_pkg::M_FRAC) && (c != "0")) begin
                  nz_d = 1'b1;
                end
              end
            end else begin
              do_flush = 1'b1;
              do_idle  = 1'b1;
            end
          end
          jt_pkg::M_KEY: begin
            if (jt_pkg::is_kw_letter(c)) begin
              // letters past the buffer only push the count off any match
              if (kcnt_q != '1) kcnt_d = kcnt_q + 1'b1;
              mt_d = mt_q && jt_pkg::kw_char_ok(jt_pkg::KwTrue, KcW'(4), kcnt_q, c);
              mf_d = mf_q && jt_pkg::kw_char_ok(jt_pkg::KwFalse, KcW'(5), kcnt_q, c);
              mn_d = mn_q && jt_pkg::kw_char_ok(jt_pkg::KwNull, KcW'(4), kcnt_q, c);
            end else begin
              do_kw   = 1'b1;
              do_idle = kw_ok;
            end
          end
          default: ;
        endcase
      end

      if (do_flush) begin
        cmd.flush  = 1'b1;
        cmd.fbank  = bank_q;
        cmd.fkind  = ((mode_q == jt_pkg::M_FRAC) && nz_q) ? jt_pkg::TK_FLOAT
                                                          : jt_pkg::TK_INT;
        cmd.fcount = ((mode_q == jt_pkg::M_FRAC) && !nz_q) ? dot_q : len_q;
        pend_d[bank_q] = 1'b1;
        bank_d   = ~bank_q;
        mode_d   = jt_pkg::M_IDLE;
        do_clear = 1'b1;
      end

      if (do_kw) begin
        cmd.a_v  = 1'b1;
        do_clear = 1'b1;
        if (kw_ok) begin
          cmd.a  = jt_pkg::tok_item(kw_kind);
          mode_d = jt_pkg::M_IDLE;
        end else begin
          cmd.a  = jt_pkg::err_item(jt_pkg::ERR_KEYWORD);
          mode_d = jt_pkg::M_ERR;
        end
      end

      if (end_of_text_i) begin
        mode_d = jt_pkg::M_IDLE;
      end

      if (do_clear) begin
        len_d  = '0;
        dot_d  = '0;
        nz_d   = 1'b0;
        kcnt_d = '0;
        mt_d   = 1'b0;
        mf_d   = 1'b0;
        mn_d   = 1'b0;
      end

      if (do_idle) begin
        mode_d = id.mode;
        if (id.emit) begin
          if (cmd.a_v) begin
            cmd.b_v = 1'b1;
            cmd.b   = id.item;
          end else begin
            cmd.a_v = 1'b1;
            cmd.a   = id.item;
          end
        end
        if (id.num_start) begin
          we    = 1'b1;
          wbank = bank_d;
          widx  = '0;
          len_d = LenW'(1);
        end
        if (id.kw_start) begin
          kcnt_d = KcW'(1);
          mt_d   = (c == "t");
          mf_d   = (c == "f");
          mn_d   = (c == "n");
        end
      end
    end
  end

  assign cmd_o       = cmd;
  assign cmd_push_o  = accept && (cmd.flush || cmd.a_v || cmd.b_v);
  assign ram_we_o    = accept && we;
  assign ram_waddr_o = {wbank, widx};
  assign ram_wdata_o = c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jt_pkg::M_IDLE;
      len_q  <= '0;
      dot_q  <= '0;
      nz_q   <= 1'b0;
      kcnt_q <= '0;
      mt_q   <= 1'b0;
      mf_q   <= 1'b0;
      mn_q   <= 1'b0;
      bank_q <= 1'b0;
      pend_q <= '0;
    end else begin
      mode_q <= mode_d;
      len_q  <= len_d;
      dot_q  <= dot_d;
      nz_q   <= nz_d;
      kcnt_q <= kcnt_d;
      mt_q   <= mt_d;
      mf_q   <= mf_d;
      mn_q   <= mn_d;
      bank_q <= bank_d;
      pend_q <= pend_d;
    end
  end

endmodule

[rtl/core/jt_back.sv]
`timescale 1ns / 1ps

module jt_back #(
  parameter int unsigned MAX_TOKEN_LEN = jt_pkg::MaxTokenLen
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  jt_pkg::cmd_t                   cmd_i,
  input  logic                           cmd_empty_i,
  output logic                           cmd_pop_o,
  output logic                           ram_re_o,
  output logic [$clog2(MAX_TOKEN_LEN):0] ram_raddr_o,
  input  logic [7:0]                     ram_rdata_i,
  output jt_pkg::done_t                  done_o,
  input  logic                           pop_i,
  output logic                           empty_o,
  output jt_pkg::res_t                   res_o
);

  localparam int unsigned IdxW  = $clog2(MAX_TOKEN_LEN);
  localparam int unsigned LenW  = jt_pkg::LenW;
  localparam int unsigned Depth = jt_pkg::OutDepth;
  localparam int unsigned CntW  = $clog2(Depth+1);

  jt_pkg::step_e   step_q, step_d, step_eff;
  logic [LenW-1:0] idx_q, idx_d;
  logic            stage_v_q;
  jt_pkg::item_t   stage_item_q;
  logic            stage_last_q, stage_ram_q;

  jt_pkg::item_t   it;
  jt_pkg::res_t    push_res;
  logic            last, from_ram, flush_last, issue;
  logic [CntW-1:0] out_cnt;
  logic [CntW:0]   used;

  assign flush_last = ((idx_q + 1'b1) == cmd_i.fcount);
  // room for the item in the stage register plus the one issued now
  assign used  = {1'b0, out_cnt} + (CntW+1)'(stage_v_q);
  assign issue = !cmd_empty_i && (used < (CntW+1)'(Depth));

  always_comb begin
    step_eff = step_q;
    priority if ((step_q == jt_pkg::ST_FLUSH) && !cmd_i.flush) begin
      step_eff = cmd_i.a_v ? jt_pkg::ST_A : jt_pkg::ST_B;
    end else if ((step_q == jt_pkg::ST_A) && !cmd_i.a_v) begin
      step_eff = jt_pkg::ST_B;
    end else begin
      step_eff = step_q;
    end
  end

  always_comb begin
    it       = '0;
    last     = 1'b0;
    from_ram = 1'b0;
    step_d   = step_q;
    idx_d    = idx_q;
    done_o   = '0;
    done_o.bank = cmd_i.fbank;
    cmd_pop_o   = 1'b0;

    unique case (step_eff)
      jt_pkg::ST_FLUSH: begin
        it.kind   = cmd_i.fkind;
        it.bvalid = 1'b1;
        it.tend   = flush_last;
        from_ram  = 1'b1;
        last      = flush_last && !cmd_i.a_v && !cmd_i.b_v;
      end
      jt_pkg::ST_A: begin
        it   = cmd_i.a;
        last = !cmd_i.b_v;
      end
      jt_pkg::ST_B: begin
        it   = cmd_i.b;
        last = 1'b1;
      end
      default: ;
    endcase

    if (issue) begin
      if (step_eff == jt_pkg::ST_FLUSH) begin
        if (flush_last) begin
          idx_d        = '0;
          step_d       = jt_pkg::ST_A;
          done_o.valid = 1'b1;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end else begin
        step_d = jt_pkg::ST_B;
      end
      if (last) begin
        cmd_pop_o = 1'b1;
        step_d    = jt_pkg::ST_FLUSH;
        idx_d     = '0;
      end
    end
  end

  assign ram_re_o    = issue && from_ram;
  assign ram_raddr_o = {cmd_i.fbank, idx_q[IdxW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= jt_pkg::ST_FLUSH;
      idx_q     <= '0;
      stage_v_q <= 1'b0;
    end else begin
      step_q    <= step_d;
      idx_q     <= idx_d;
      stage_v_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      stage_item_q <= it;
      stage_last_q <= last;
      stage_ram_q  <= from_ram;
    end
  end

  always_comb begin
    push_res            = '0;
    push_res.item       = stage_item_q;
    push_res.last       = stage_last_q;
    if (stage_ram_q) push_res.item.vbyte = ram_rdata_i;
  end

  jt_fifo #(
    .WIDTH ($bits(jt_pkg::res_t)),
    .DEPTH (Depth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (stage_v_q),
    .wdata_i (push_res),
    .full_o  (),
    .pop_i   (pop_i),
    .rdata_o (res_o),
    .empty_o (empty_o),
    .cnt_o   (out_cnt)
  );

endmodule
